### sv/wopg_pkg.sv
`default_nettype none

package wopg_pkg;

  localparam int MAX_BITS = 32;
  localparam int WEIGHT_W = 6;
  localparam int CFG_W    = 6;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Stream packing
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = CMD_W;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_TUSER_W  = 1;
  localparam int OUT_WEIGHT_LO = MAX_BITS;

  localparam logic [CFG_W-1:0] LENGTH_RESET = CFG_W'(8);
  localparam logic [CFG_W-1:0] MIN_W_RESET  = CFG_W'(0);
  localparam logic [CFG_W-1:0] MAX_W_RESET  = CFG_W'(8);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_MIN_W  = 2'd1,
    CFG_MAX_W  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] length;
    logic [CFG_W-1:0] min_w;
    logic [CFG_W-1:0] max_w;
  } cfg_t;

  typedef struct packed {
    logic [MAX_BITS-1:0] pattern;
    logic [WEIGHT_W-1:0] weight;
    logic [MAX_BITS-1:0] last;
    logic                before_first;
  } gen_state_t;

  typedef struct packed {
    logic                advanced;
    logic [WEIGHT_W-1:0] weight;
    logic [MAX_BITS-1:0] pattern;
  } result_t;

  // w low bits set; w at or above MAX_BITS gives all ones
  function automatic logic [MAX_BITS-1:0] low_ones(input logic [WEIGHT_W-1:0] w);
    logic [MAX_BITS:0] m;
    m = ~({(MAX_BITS+1){1'b1}} << w);
    return m[MAX_BITS-1:0];
  endfunction

  function automatic logic [MAX_BITS-1:0] top_aligned(input logic [WEIGHT_W-1:0] len,
                                                      input logic [WEIGHT_W-1:0] w);
    logic [MAX_BITS-1:0] r;
    if (w == '0 || w > len) begin
      r = '0;
    end else begin
      r = low_ones(w) << (len - w);
    end
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] popcount(input logic [MAX_BITS-1:0] v);
    logic [WEIGHT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      n = n + WEIGHT_W'(v[i]);
    end
    return n;
  endfunction

  // position of the single set bit of a one-hot word
  function automatic logic [$clog2(MAX_BITS)-1:0] onehot_index(input logic [MAX_BITS-1:0] c);
    logic [$clog2(MAX_BITS)-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (c[i]) n = n | ($clog2(MAX_BITS))'(i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### sv/wopg_step.sv
`default_nettype none

module wopg_step (
  input  wire wopg_pkg::cfg_t                      cfg,
  input  wire wopg_pkg::gen_state_t                state,
  input  wire logic [wopg_pkg::CMD_W-1:0]          command,
  input  wire logic [wopg_pkg::MAX_BITS-1:0]       load_pattern,
  output wopg_pkg::gen_state_t                     state_next,
  output wopg_pkg::result_t                        res
);
  import wopg_pkg::*;

  logic [WEIGHT_W-1:0] eff_len;
  logic [WEIGHT_W-1:0] eff_max;
  logic [WEIGHT_W-1:0] start_w;
  logic [MAX_BITS-1:0] low_bit;
  logic [MAX_BITS-1:0] sum;
  logic [MAX_BITS-1:0] gosper;
  logic [MAX_BITS-1:0] masked;
  logic [WEIGHT_W-1:0] load_w;
  logic                adv;

  always_comb begin
    if (cfg.length == '0) begin
      eff_len = WEIGHT_W'(1);
    end else if (cfg.length > WEIGHT_W'(MAX_BITS)) begin
      eff_len = WEIGHT_W'(MAX_BITS);
    end else begin
      eff_len = cfg.length;
    end
    eff_max = (cfg.max_w > eff_len) ? eff_len : cfg.max_w;
  end

  // next combination of the same weight
  always_comb begin
    low_bit = state.pattern & (~state.pattern + MAX_BITS'(1));
    sum     = state.pattern + low_bit;
    if (low_bit == '0) begin
      gosper = '0;
    end else begin
      gosper = (((sum ^ state.pattern) >> 2) >> onehot_index(low_bit)) | sum;
    end
  end

  assign masked = load_pattern & low_ones(eff_len);
  assign load_w = popcount(masked);

  always_comb begin
    state_next = state;
    adv        = 1'b0;
    start_w    = state.before_first ? cfg.min_w : state.weight + WEIGHT_W'(1);
    unique case (cmd_t'(command))
      CMD_ADVANCE: begin
        if (state.before_first ? (cfg.min_w <= eff_max) : 1'b0) begin
          adv = 1'b1;
        end else if (!state.before_first && state.pattern < state.last) begin
          state_next.pattern = gosper;
          adv = 1'b1;
        end else if (!state.before_first && state.weight < eff_max) begin
          adv = 1'b1;
        end
        if (adv && (state.before_first || state.pattern >= state.last)) begin
          state_next.weight       = start_w;
          state_next.pattern      = low_ones(start_w);
          state_next.last         = top_aligned(eff_len, start_w);
          state_next.before_first = 1'b0;
        end
      end
      CMD_LOAD: begin
        state_next.pattern      = masked;
        state_next.weight       = load_w;
        state_next.last         = top_aligned(eff_len, load_w);
        state_next.before_first = 1'b0;
        adv = 1'b1;
      end
      CMD_RESTART: begin
        state_next.pattern      = '0;
        state_next.weight       = '0;
        state_next.last         = '0;
        state_next.before_first = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res.pattern  = state_next.pattern;
  assign res.weight   = state_next.weight;
  assign res.advanced = adv;

endmodule

`default_nettype wire

### sv/weight_ordered_pattern_generator.sv
// Weight-ordered pattern generator.
// Walks every pattern of pattern_length bits in order of rising popcount,
// from the lowest to the highest configured weight, stepping by the
// next-combination rule inside one weight.
// Input stream (s_*): s_tuser carries the command (advance, load, restart),
// s_tdata the pattern used by a load. Every accepted beat yields exactly one
// output beat on m_*: pattern and weight in m_tdata, the advanced flag in
// m_tuser (low when the range is exhausted, on restart or an unused command).
// Configuration: cfg_valid/cfg_index/cfg_data write pattern_length,
// the lowest or the highest weight; cfg_ready is always high. Write only while idle.
// The result beat is registered. Throughput: one beat per cycle while s_tready is
// high, set by the combinational update of the generator state (isolate low bit,
// add, shift by its index, compare against the last pattern).
// Stall: a two-entry output buffer (output register plus skid register)
// takes one more beat while the receiver stalls, then s_tready drops until
// the receiver takes a beat.
// Reset (rst, synchronous): registers return to length 8, weights 0..8, the
// generator sits before the first pattern, and both buffers are emptied.
`default_nettype none

module weight_ordered_pattern_generator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [wopg_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] load_pattern
  input  wire logic [wopg_pkg::IN_TUSER_W-1:0]     s_tuser,   // [1:0] command
  // master stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [wopg_pkg::OUT_TDATA_W-1:0]         m_tdata,   // [31:0] pattern, [37:32] weight
  output logic [wopg_pkg::OUT_TUSER_W-1:0]         m_tuser,   // [0] advanced
  // configuration write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [wopg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wopg_pkg::CFG_W-1:0]          cfg_data
);
  import wopg_pkg::*;

  cfg_t       cfg;
  gen_state_t state;
  gen_state_t state_next;
  result_t    res;
  result_t    out_res;
  result_t    skid_res;
  logic       out_valid;
  logic       skid_valid;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length <= LENGTH_RESET;
      cfg.min_w  <= MIN_W_RESET;
      cfg.max_w  <= MAX_W_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LENGTH: cfg.length <= cfg_data;
        CFG_MIN_W:  cfg.min_w  <= cfg_data;
        CFG_MAX_W:  cfg.max_w  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wopg_step u_step (
    .cfg          (cfg),
    .state        (state),
    .command      (s_tuser),
    .load_pattern (s_tdata[MAX_BITS-1:0]),
    .state_next   (state_next),
    .res          (res)
  );

  // advance the generator state on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pattern      <= '0;
      state.weight       <= '0;
      state.last         <= '0;
      state.before_first <= 1'b1;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output register with skid: drain skid first, park a new beat in skid on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - MAX_BITS - WEIGHT_W)'(0), out_res.weight, out_res.pattern};
  assign m_tuser  = out_res.advanced;

endmodule

`default_nettype wire

### sv/wopg_checker.sv
`default_nettype none

module wopg_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [wopg_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input wire logic [wopg_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import wopg_pkg::*;

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // weight field tracks the pattern popcount
  a_weight_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[MAX_BITS-1:0]) ==
                 int'(m_tdata[OUT_WEIGHT_LO +: WEIGHT_W]))
    else $error("weight does not match pattern");

  // input backpressure only while an output beat waits
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("s_tready low with empty output");

  // a full buffer stays full while the receiver stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !m_tready |=> !s_tready)
    else $error("skid released without output beat taken");

endmodule

bind weight_ordered_pattern_generator wopg_checker u_wopg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/weight_ordered_pattern_checker.sv
module weight_ordered_pattern_checker
  import wopg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] load_pattern
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] command
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] pattern, [37:32] weight
  input  wire logic [OUT_TUSER_W-1:0] m_tuser,   // [0] advanced
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  output int                          outstanding,
  output int                          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_W-1:0]    reg_len;
  logic [CFG_W-1:0]    reg_min;
  logic [CFG_W-1:0]    reg_max;
  logic [63:0]         cur_pat;
  logic [63:0]         cur_last;
  logic [WEIGHT_W-1:0] cur_wt;
  bit                  fresh;
  result_t             queued_patterns[$];

  function automatic logic [CFG_W-1:0] usable_len();
    logic [CFG_W-1:0] l;
    l = reg_len;
    if (l == '0) l = CFG_W'(1);
    if (l > MAX_BITS) l = CFG_W'(MAX_BITS);
    return l;
  endfunction

  function automatic logic [CFG_W-1:0] weight_ceiling();
    logic [CFG_W-1:0] l;
    l = usable_len();
    return (reg_max > l) ? l : reg_max;
  endfunction

  function automatic logic [63:0] ones_below(input logic [WEIGHT_W-1:0] w);
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [63:0] top_fill(input logic [CFG_W-1:0] len,
                                           input logic [WEIGHT_W-1:0] w);
    if (w == '0 || w > len) return 64'd0;
    return ones_below(w) << (len - w);
  endfunction

  function automatic int low_zero_run(input logic [63:0] c);
    int n;
    n = 0;
    while (n < 63 && !c[n]) n++;
    return n;
  endfunction

  // Start a weight right-aligned; its last pattern is the top-aligned one.
  task automatic open_weight(input logic [WEIGHT_W-1:0] w);
    cur_wt   = w;
    cur_pat  = ones_below(w);
    cur_last = top_fill(usable_len(), w);
    fresh    = 1'b0;
  endtask

  task automatic predict_pattern(input logic [CMD_W-1:0] cmd, input logic [31:0] load_val,
                                 output result_t res);
    logic [63:0] v;
    logic [63:0] c;
    logic [63:0] s;
    logic        adv;
    adv = 1'b0;
    case (cmd)
      CMD_ADVANCE: begin
        if (fresh) begin
          if (reg_min <= weight_ceiling()) begin
            open_weight(reg_min);
            adv = 1'b1;
          end
        end else if (cur_pat < cur_last) begin
          // next combination of the same weight
          v = cur_pat;
          c = v & (~v + 64'd1);
          if (c != 64'd0) begin
            s = v + c;
            v = (((s ^ v) >> 2) >> low_zero_run(c)) | s;
          end else begin
            v = 64'd0;
          end
          cur_pat = v;
          adv = 1'b1;
        end else if (cur_wt < weight_ceiling()) begin
          open_weight(WEIGHT_W'(cur_wt + 1));
          adv = 1'b1;
        end
      end
      CMD_LOAD: begin
        cur_pat  = {32'd0, load_val} & ones_below(usable_len());
        cur_wt   = WEIGHT_W'($countones(cur_pat));
        cur_last = top_fill(usable_len(), cur_wt);
        fresh    = 1'b0;
        adv      = 1'b1;
      end
      CMD_RESTART: begin
        cur_pat  = 64'd0;
        cur_wt   = '0;
        cur_last = 64'd0;
        fresh    = 1'b1;
      end
      default: ;
    endcase
    res.pattern  = cur_pat[MAX_BITS-1:0];
    res.weight   = cur_wt;
    res.advanced = adv;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      reg_len  = LENGTH_RESET;
      reg_min  = MIN_W_RESET;
      reg_max  = MAX_W_RESET;
      cur_pat  = 64'd0;
      cur_last = 64'd0;
      cur_wt   = '0;
      fresh    = 1'b1;
      queued_patterns.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LENGTH: reg_len = cfg_data;
          CFG_MIN_W:  reg_min = cfg_data;
          CFG_MAX_W:  reg_max = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.pattern  = m_tdata[MAX_BITS-1:0];
        got.weight   = m_tdata[OUT_WEIGHT_LO +: WEIGHT_W];
        got.advanced = m_tuser[0];
        if (queued_patterns.size() == 0) begin
          $display("%0t ERROR: unexpected beat pattern=%h weight=%0d advanced=%0b",
                   $realtime, got.pattern, got.weight, got.advanced);
          mismatches++;
        end else begin
          want = queued_patterns.pop_front();
          if (got !== want) begin
            $display("%0t ERROR: expected pattern=%h weight=%0d advanced=%0b, actual pattern=%h weight=%0d advanced=%0b",
                     $realtime, want.pattern, want.weight, want.advanced,
                     got.pattern, got.weight, got.advanced);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_pattern(s_tuser, s_tdata[31:0], want);
        queued_patterns.push_back(want);
      end
    end
    outstanding = queued_patterns.size();
  end

endmodule

### tb/sv/tb_weight_ordered_pattern_generator.sv
module tb_weight_ordered_pattern_generator;
  import wopg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code the block does not define; it must leave the state alone.
  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  localparam int RX_HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int BEATS_PER_SET  = 47;

  // Idle percentages per pass: sender, then receiver.
  localparam int TX_PCT[3] = '{22, 83, 0};
  localparam int RX_PCT[3] = '{83, 22, 0};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [31:0] load_pattern
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // [1:0] command
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] pattern, [37:32] weight
  logic [OUT_TUSER_W-1:0] m_tuser;        // [0] advanced
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int          outstanding;
  int          mismatches;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int unsigned cycle_count = 0;

  weight_ordered_pattern_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  weight_ordered_pattern_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weight_ordered_pattern_generator test failed");
      $finish;
    end
  end

  // Receiver. Drop tready at random, or hold it low for a long stretch when
  // the stimulus toggles hold_req, so the output buffer fills and the block
  // has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        hold_ack = hold_req;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one beat, with random idle cycles in front of it, and return at
  // the edge where it is taken. tvalid stays high into the next beat when no
  // idle cycle falls between them.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [31:0] data);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  // Present one register write and return at the edge where it is taken.
  // The caller drops cfg_valid after the last write of a sequence.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] min_w,
                              input logic [CFG_W-1:0] max_w);
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_MIN_W, min_w);
    write_reg(CFG_MAX_W, max_w);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering beats, wait until every predicted beat came back, then
  // let the registered result path go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  // Mostly advances so enumerations run through several weights; loads,
  // restarts and the unused code break in now and then.
  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 76) return CMD_ADVANCE;
    if (r < 88) return CMD_LOAD;
    if (r < 95) return CMD_RESTART;
    return CMD_UNUSED;
  endfunction

  // Short lengths keep the walks short enough to hit weight changes and
  // exhaustion; the odd extreme length shows up too.
  task automatic random_regs();
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] min_w;
    logic [CFG_W-1:0] max_w;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: len = CFG_W'(0);
        1: len = CFG_W'(32);
        2: len = CFG_W'(33);
        default: len = CFG_W'(63);
      endcase
    end else begin
      len = CFG_W'($urandom_range(1, 7));
    end
    min_w = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(63)) : CFG_W'($urandom_range(4));
    max_w = ($urandom_range(7) == 0) ? CFG_W'(63) : CFG_W'($urandom_range(min_w, 9));
    program_regs(len, min_w, max_w);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = TX_PCT[0];
    rx_idle_pct = RX_PCT[0];

    // Reset registers: length 8, weights 0 to 8. First advance gives the
    // empty pattern, then weight one starts right-aligned.
    send_beat(CMD_ADVANCE, 32'hFFFF_FFFF);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    // Load all ones: masked to eight bits, top weight, so next advance exhausts.
    send_beat(CMD_LOAD, 32'hFFFF_FFFF);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_LOAD, 32'hA5A5_A5A5);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_UNUSED, 32'h0000_0000);
    send_beat(CMD_RESTART, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);

    // Full width, only weight 32, max saturating to the length.
    settle();
    write_reg(CFG_SPARE, CFG_W'(63));
    program_regs(CFG_W'(32), CFG_W'(32), CFG_W'(63));
    send_beat(CMD_RESTART, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_LOAD, 32'h8000_0001);
    send_beat(CMD_ADVANCE, 32'h0000_0000);

    // Length zero acts as one bit.
    settle();
    program_regs(CFG_W'(0), CFG_W'(0), CFG_W'(1));
    send_beat(CMD_RESTART, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);

    // Min above max: empty range. A load then sits outside the range.
    settle();
    program_regs(CFG_W'(5), CFG_W'(3), CFG_W'(2));
    send_beat(CMD_RESTART, 32'h0000_0000);
    send_beat(CMD_ADVANCE, 32'h0000_0000);
    send_beat(CMD_LOAD, 32'h0000_001F);
    send_beat(CMD_ADVANCE, 32'h0000_0000);

    // Random sets under three idling passes; one long receiver hold-off in
    // the second pass and one in the pass without idling.
    for (int pass = 0; pass < 3; pass++) begin
      tx_idle_pct = TX_PCT[pass];
      rx_idle_pct = RX_PCT[pass];
      for (int set = 0; set < 6; set++) begin
        settle();
        random_regs();
        if ((pass == 1 && set == 4) || (pass == 2 && set == 1)) hold_req = ~hold_req;
        repeat (BEATS_PER_SET) send_beat(pick_command(), $urandom());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("weight_ordered_pattern_generator test passed");
    end else begin
      $display("weight_ordered_pattern_generator test failed");
    end
    $finish;
  end

endmodule

### weight_ordered_pattern_generator.f
sv/wopg_pkg.sv
sv/wopg_step.sv
sv/weight_ordered_pattern_generator.sv
sv/wopg_checker.sv
tb/sv/weight_ordered_pattern_checker.sv
tb/sv/tb_weight_ordered_pattern_generator.sv
